// File: src/lc2k_pkg.sv
// Shared types, codes and microprogram for the LC2K instruction simulator.
`default_nettype none

package lc2k_pkg;

    // Architectural sizes fixed by the instruction format
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PC_W      = 16;
    localparam int unsigned SIZE_W    = 17;

    // Run status codes as reported on the result channel
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALTED  = 3'd1,
        ST_BADADDR = 3'd2,
        ST_BADOP   = 3'd3,
        ST_BADPC   = 3'd4
    } status_t;

    // Legal opcodes (low three bits of the opcode field)
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NAND = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_CMOV = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } op_t;

    // Request kind carried on the input tuser
    localparam logic OPER_WRITE = 1'b0;
    localparam logic OPER_STEP  = 1'b1;

    // Jump conditions tested by the sequencer
    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_ACCEPT   = 3'd1,
        COND_IS_WRITE = 3'd2,
        COND_CAN_RUN  = 3'd3,
        COND_LOAD_GO  = 3'd4,
        COND_OUT_FREE = 3'd5
    } cond_t;

    typedef logic [3:0] step_t;

    // Microprogram step addresses
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DISPATCH = 4'd1;
    localparam step_t STEP_WRITE    = 4'd2;
    localparam step_t STEP_CHECK    = 4'd3;
    localparam step_t STEP_BADPC    = 4'd4;
    localparam step_t STEP_FETCH    = 4'd5;
    localparam step_t STEP_DECODE   = 4'd6;
    localparam step_t STEP_EXEC     = 4'd7;
    localparam step_t STEP_LOAD_WB  = 4'd8;
    localparam step_t STEP_OUT      = 4'd9;

    // Datapath strobes of one control word
    typedef struct packed {
        logic ready;      // take an input request
        logic wr_in;      // write input word to memory
        logic fetch;      // read memory at pc, bump count
        logic latch_ir;   // capture instruction and register operands
        logic exec;       // execute the latched instruction
        logic load_wb;    // write loaded word back, advance pc
        logic set_badpc;  // flag pc out of range
        logic out_load;   // hand the result to the output register
    } ctl_t;

    typedef struct packed {
        ctl_t  ctl;
        cond_t cond;
        step_t t_true;
        step_t t_false;
    } ucw_t;

    // Condition inputs seen by the sequencer
    typedef struct packed {
        logic accept;
        logic is_write;
        logic can_run;
        logic load_go;
        logic out_free;
    } flags_t;

    // Microprogram ROM
    function automatic ucw_t ucode_rom(input step_t step);
        ucw_t w;
        w         = '0;
        w.cond    = COND_ALWAYS;
        w.t_true  = STEP_IDLE;
        w.t_false = STEP_IDLE;
        unique case (step)
            STEP_IDLE: begin
                w.ctl.ready = 1'b1;
                w.cond      = COND_ACCEPT;
                w.t_true    = STEP_DISPATCH;
                w.t_false   = STEP_IDLE;
            end
            STEP_DISPATCH: begin
                w.cond    = COND_IS_WRITE;
                w.t_true  = STEP_WRITE;
                w.t_false = STEP_CHECK;
            end
            STEP_WRITE: begin
                w.ctl.wr_in = 1'b1;
                w.t_true    = STEP_OUT;
                w.t_false   = STEP_OUT;
            end
            STEP_CHECK: begin
                w.cond    = COND_CAN_RUN;
                w.t_true  = STEP_FETCH;
                w.t_false = STEP_BADPC;
            end
            STEP_BADPC: begin
                w.ctl.set_badpc = 1'b1;
                w.t_true        = STEP_OUT;
                w.t_false       = STEP_OUT;
            end
            STEP_FETCH: begin
                w.ctl.fetch = 1'b1;
                w.t_true    = STEP_DECODE;
                w.t_false   = STEP_DECODE;
            end
            STEP_DECODE: begin
                w.ctl.latch_ir = 1'b1;
                w.t_true       = STEP_EXEC;
                w.t_false      = STEP_EXEC;
            end
            STEP_EXEC: begin
                w.ctl.exec = 1'b1;
                w.cond     = COND_LOAD_GO;
                w.t_true   = STEP_LOAD_WB;
                w.t_false  = STEP_OUT;
            end
            STEP_LOAD_WB: begin
                w.ctl.load_wb = 1'b1;
                w.t_true      = STEP_OUT;
                w.t_false     = STEP_OUT;
            end
            STEP_OUT: begin
                w.ctl.out_load = 1'b1;
                w.cond         = COND_OUT_FREE;
                w.t_true       = STEP_IDLE;
                w.t_false      = STEP_OUT;
            end
            default: begin
                w.t_true  = STEP_IDLE;
                w.t_false = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: src/lc2k_ucode_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module lc2k_ucode_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lc2k_pkg::flags_t flags,
    output lc2k_pkg::ctl_t       ctl
);

    lc2k_pkg::step_t step_reg;
    lc2k_pkg::step_t step_next;
    lc2k_pkg::ucw_t  ucw;
    logic            hit;

    // Control word for the current step
    assign ucw = lc2k_pkg::ucode_rom(step_reg);
    assign ctl = ucw.ctl;

    // Condition select
    always_comb
    begin
        unique case (ucw.cond)
            lc2k_pkg::COND_ALWAYS:   hit = 1'b1;
            lc2k_pkg::COND_ACCEPT:   hit = flags.accept;
            lc2k_pkg::COND_IS_WRITE: hit = flags.is_write;
            lc2k_pkg::COND_CAN_RUN:  hit = flags.can_run;
            lc2k_pkg::COND_LOAD_GO:  hit = flags.load_go;
            lc2k_pkg::COND_OUT_FREE: hit = flags.out_free;
            default:                 hit = 1'b0;
        endcase
    end

    assign step_next = hit ? ucw.t_true : ucw.t_false;

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lc2k_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lc2k_datapath.sv
// Datapath: word memory, register file, pc, count, status and ALU.
`default_nettype none

module lc2k_datapath #(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [lc2k_pkg::SIZE_W-1:0]  cfg_wdata,
    input  wire logic                         in_accept,
    input  wire logic                         in_oper,
    input  wire logic [lc2k_pkg::PC_W-1:0]    in_addr,
    input  wire logic [lc2k_pkg::WORD_W-1:0]  in_data,
    input  wire lc2k_pkg::ctl_t               ctl,
    output logic                              is_write,
    output logic                              can_run,
    output logic                              load_go,
    output logic [2:0]                        status,
    output logic [lc2k_pkg::PC_W-1:0]         pc,
    output logic [lc2k_pkg::WORD_W-1:0]       count
);

    localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [lc2k_pkg::SIZE_W-1:0] MemLimit = lc2k_pkg::SIZE_W'(MEM_WORDS);

    // Configured bound, already clipped to the memory size
    logic [lc2k_pkg::SIZE_W-1:0] bound_reg;
    logic [lc2k_pkg::SIZE_W-1:0] bound_next;

    // Latched request
    logic                        oper_reg;
    logic [lc2k_pkg::PC_W-1:0]   addr_reg;
    logic [lc2k_pkg::WORD_W-1:0] data_reg;

    // Memory
    logic [lc2k_pkg::WORD_W-1:0] mem [MEM_WORDS];
    logic [lc2k_pkg::WORD_W-1:0] rdata_reg;
    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [lc2k_pkg::WORD_W-1:0] mem_wdata;

    // Instruction and operands
    logic [lc2k_pkg::WORD_W-1:0] ir_reg;
    logic [lc2k_pkg::WORD_W-1:0] a_reg;
    logic [lc2k_pkg::WORD_W-1:0] b_reg;
    logic [lc2k_pkg::WORD_W-1:0] rf_reg [lc2k_pkg::REG_COUNT];

    // Architectural state
    logic [lc2k_pkg::PC_W-1:0]   pc_reg;
    logic [lc2k_pkg::PC_W-1:0]   pc_next;
    lc2k_pkg::status_t           status_reg;
    lc2k_pkg::status_t           status_next;
    logic [lc2k_pkg::WORD_W-1:0] count_reg;
    logic [lc2k_pkg::WORD_W-1:0] count_next;

    // Register file write port
    logic                        rf_we;
    logic [2:0]                  rf_waddr;
    logic [lc2k_pkg::WORD_W-1:0] rf_wdata;

    // Decode fields
    logic                        op_bad;
    lc2k_pkg::op_t               opc;
    logic [2:0]                  rb;
    logic [2:0]                  rd;
    logic [15:0]                 off;
    logic [lc2k_pkg::WORD_W-1:0] daddr;
    logic                        addr_ok;
    logic                        taken;
    logic [17:0]                 next_pc;
    logic                        next_ok;
    logic                        wr_in_ok;

    assign op_bad = |ir_reg[31:25];
    assign opc    = lc2k_pkg::op_t'(ir_reg[24:22]);
    assign rb     = ir_reg[18:16];
    assign rd     = ir_reg[2:0];
    assign off    = ir_reg[15:0];

    // Data address and its range check (signed, against the bound)
    assign daddr   = a_reg + {{16{off[15]}}, off};
    assign addr_ok = !daddr[31] && (daddr < {15'd0, bound_reg});

    // Next pc: pc + 1, plus the offset for a taken branch
    assign taken   = (opc == lc2k_pkg::OP_BEQ) && (a_reg == b_reg);
    assign next_pc = {2'b00, pc_reg} + 18'd1 + (taken ? {{2{off[15]}}, off} : 18'd0);
    assign next_ok = !next_pc[17] && (next_pc < {1'b0, bound_reg});

    // Sequencer conditions
    assign is_write = (oper_reg == lc2k_pkg::OPER_WRITE);
    assign can_run  = (status_reg == lc2k_pkg::ST_OK) && ({1'b0, pc_reg} < bound_reg);
    assign load_go  = !op_bad && (opc == lc2k_pkg::OP_LW) && addr_ok;

    assign wr_in_ok = ({1'b0, addr_reg} < MemLimit);

    // Memory port control
    always_comb
    begin
        mem_we    = (ctl.wr_in && wr_in_ok) ||
                    (ctl.exec && !op_bad && (opc == lc2k_pkg::OP_SW) && addr_ok);
        mem_waddr = ctl.wr_in ? addr_reg[AW-1:0] : daddr[AW-1:0];
        mem_wdata = ctl.wr_in ? data_reg : b_reg;
        mem_re    = ctl.fetch || (ctl.exec && load_go);
        mem_raddr = ctl.fetch ? pc_reg[AW-1:0] : daddr[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Bound update on a configuration write
    always_comb
    begin
        bound_next = bound_reg;
        if (cfg_we)
        begin
            bound_next = (cfg_wdata < MemLimit) ? cfg_wdata : MemLimit;
        end
    end

    // Execute: state updates per opcode
    always_comb
    begin
        pc_next     = pc_reg;
        status_next = status_reg;
        count_next  = count_reg;
        rf_we       = 1'b0;
        rf_waddr    = rd;
        rf_wdata    = a_reg + b_reg;

        if (ctl.fetch)
        begin
            count_next = count_reg + 32'd1;
        end

        if (ctl.set_badpc && (status_reg == lc2k_pkg::ST_OK))
        begin
            status_next = lc2k_pkg::ST_BADPC;
        end

        if (ctl.exec)
        begin
            if (op_bad)
            begin
                status_next = lc2k_pkg::ST_BADOP;
            end
            else
            begin
                unique case (opc)
                    lc2k_pkg::OP_ADD,
                    lc2k_pkg::OP_NAND,
                    lc2k_pkg::OP_CMOV,
                    lc2k_pkg::OP_BEQ,
                    lc2k_pkg::OP_NOOP,
                    lc2k_pkg::OP_SW: begin
                        if ((opc == lc2k_pkg::OP_SW) && !addr_ok)
                        begin
                            status_next = lc2k_pkg::ST_BADADDR;
                        end
                        else
                        begin
                            pc_next = next_pc[15:0];
                            if (!next_ok)
                            begin
                                status_next = lc2k_pkg::ST_BADPC;
                            end
                        end
                        if (opc == lc2k_pkg::OP_ADD)
                        begin
                            rf_we = 1'b1;
                        end
                        if (opc == lc2k_pkg::OP_NAND)
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = ~(a_reg & b_reg);
                        end
                        if (opc == lc2k_pkg::OP_CMOV)
                        begin
                            rf_we    = (b_reg != '0);
                            rf_wdata = a_reg;
                        end
                    end
                    lc2k_pkg::OP_LW: begin
                        // in range: the load finishes in the write-back step
                        if (!addr_ok)
                        begin
                            status_next = lc2k_pkg::ST_BADADDR;
                        end
                    end
                    lc2k_pkg::OP_HALT: begin
                        pc_next     = pc_reg + 16'd1;
                        status_next = lc2k_pkg::ST_HALTED;
                    end
                    default: begin
                        status_next = status_reg;
                    end
                endcase
            end
        end

        if (ctl.load_wb)
        begin
            rf_we    = 1'b1;
            rf_waddr = rb;
            rf_wdata = rdata_reg;
            pc_next  = next_pc[15:0];
            if (!next_ok)
            begin
                status_next = lc2k_pkg::ST_BADPC;
            end
        end
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg  <= '0;
            pc_reg     <= '0;
            status_reg <= lc2k_pkg::ST_OK;
            count_reg  <= '0;
            for (int i = 0; i < lc2k_pkg::REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            bound_reg  <= bound_next;
            pc_reg     <= pc_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            if (rf_we)
            begin
                rf_reg[rf_waddr] <= rf_wdata;
            end
        end
    end

    // Payload registers: request latch, instruction and operands
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            oper_reg <= in_oper;
            addr_reg <= in_addr;
            data_reg <= in_data;
        end
        if (ctl.latch_ir)
        begin
            ir_reg <= rdata_reg;
            a_reg  <= rf_reg[rdata_reg[21:19]];
            b_reg  <= rf_reg[rdata_reg[18:16]];
        end
    end

    assign status = status_reg;
    assign pc     = pc_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

// File: src/lc2k_instruction_simulator.sv
// Top level of the LC2K instruction simulator: stream ports and result register.
//
// Input requests arrive on s_axis: tuser selects a memory word write (0) or
// one instruction step (1); tdata carries the write address and word. Every
// request yields exactly one result on m_axis with the run status, the pc
// and the executed-instruction count. program_size is set through cfg_we /
// cfg_wdata while no request is in flight.
// A microcoded sequencer steps a word memory and the register file; the
// memory accesses set the pace. A write request passes the dispatch, write
// and output steps; a step while stopped or out of range passes dispatch,
// check, bad-pc and output; an executed instruction passes dispatch, check,
// fetch, decode, execute and output; a load word adds a write-back step for
// its extra data read. The next request is taken once the current result
// sits in the output register, even if not yet drained.
// If m_axis_tready stays low the sequencer waits with the next result.
// Reset clears the register file, pc, count, status and program_size; memory
// contents are undefined until written.
`default_nettype none

module lc2k_instruction_simulator #(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,      // program_size
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // address[15:0], data[47:16]
    input  wire logic [0:0]  s_axis_tuser,   // operation[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata    // status[2:0], program_counter[18:3],
                                             // executed_count[50:19], zero fill
);

    lc2k_pkg::ctl_t   ctl;
    lc2k_pkg::flags_t flags;
    logic             in_accept;
    logic             out_free;
    logic             out_load;
    logic             is_write;
    logic             can_run;
    logic             load_go;
    logic [2:0]       status;
    logic [15:0]      pc;
    logic [31:0]      count;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [55:0]      m_data_reg;

    // Input handshake
    assign s_axis_tready = ctl.ready;
    assign in_accept     = s_axis_tvalid && ctl.ready;

    // Output register is free when empty or being drained
    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_load = ctl.out_load && out_free;

    always_comb
    begin
        flags.accept   = in_accept;
        flags.is_write = is_write;
        flags.can_run  = can_run;
        flags.load_go  = load_go;
        flags.out_free = out_free;
    end

    lc2k_ucode_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    lc2k_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_oper   (s_axis_tuser[0]),
        .in_addr   (s_axis_tdata[15:0]),
        .in_data   (s_axis_tdata[47:16]),
        .ctl       (ctl),
        .is_write  (is_write),
        .can_run   (can_run),
        .load_go   (load_go),
        .status    (status),
        .pc        (pc),
        .count     (count)
    );

    // Result register valid
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {5'd0, count, pc, status};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire
